### rtl/core/assert_macros.svh
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/bb3_pkg.sv
// Package: constants, types and helpers of the 3x3 box blur
package bb3_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int MAX_ROWS  = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int DIM_W     = 12;
    localparam int PIX_W     = 24;
    localparam int CH_W      = 8;
    localparam int CSUM_W    = 10;
    localparam int TSUM_W    = 12;

    localparam logic [DIM_W-1:0] WIDTH_RESET = 12'd640;
    localparam logic [DIM_W-1:0] ROWS_RESET  = 12'd480;
    localparam logic [DIM_W-1:0] DIM_MIN     = 12'd3;

    // ceil(2^16 / 9); exact floor(x/9) for x < 32768
    localparam logic [12:0] DIV9_MULT = 13'd7282;

    typedef enum logic [0:0] {
        CFG_LINE_WIDTH = 1'b0,
        CFG_FRAME_ROWS = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [CSUM_W-1:0] red;
        logic [CSUM_W-1:0] green;
        logic [CSUM_W-1:0] blue;
    } t_col_sum;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        begin
            if (v < DIM_MIN) r = DIM_MIN;
            else if (v > hi) r = hi;
            else r = v;
            return r;
        end
    endfunction

    function automatic logic [CH_W-1:0] div9(input logic [TSUM_W-1:0] x);
        logic [TSUM_W+12:0] prod;
        begin
            prod = (TSUM_W+13)'(x) * (TSUM_W+13)'(DIV9_MULT);
            return prod[23:16];
        end
    endfunction

    function automatic logic [CSUM_W-1:0] add3(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b,
                                               input logic [CH_W-1:0] c);
        return CSUM_W'(a) + CSUM_W'(b) + CSUM_W'(c);
    endfunction

endpackage

### rtl/core/box_blur_3x3_rgb_unit.sv
// Top level: 3x3 box blur over an RGB pixel stream with two line buffers
//
//  channel  | valid    | stall    | word
//  ---------+----------+----------+-------------------------------------------
//  pixel in | i_valid  | o_stall  | i_red_in, i_green_in, i_blue_in, i_frame_start
//  blur out | o_valid  | i_stall  | o_red_out, o_green_out, o_blue_out, o_frame_last
//  config   | i_cfg_we | -        | i_cfg_index, i_cfg_data
//
// One pixel per clock while o_stall is low; a result passes stage 1, then the output register.
// Stage 1 holds the pixel while the line buffer RAM read is registered; stage 2 is the output register.
// Border pixels give no word. Reset is synchronous, active low; no clearing pass.
// o_stall rises only while a full output register is stalled and stage 1 is occupied.
module box_blur_3x3_rgb_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [7:0]                i_red_in,
    input  logic [7:0]                i_green_in,
    input  logic [7:0]                i_blue_in,
    input  logic                      i_frame_start,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [7:0]                o_red_out,
    output logic [7:0]                o_green_out,
    output logic [7:0]                o_blue_out,
    output logic                      o_frame_last,
    input  logic                      i_cfg_we,
    input  bb3_pkg::t_cfg_index       i_cfg_index,
    input  logic [bb3_pkg::DIM_W-1:0] i_cfg_data
);
    import bb3_pkg::*;
    `include "assert_macros.svh"

    // configuration, stored already clamped
    logic [DIM_W-1:0] r_w_eff, r_h_eff;

    // position counters
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] w_col_cur;
    logic [ROW_W-1:0] w_row_cur;

    // stage 1
    logic             r_s1_valid;
    t_pixel           r_s1_pix;
    logic [COL_W-1:0] r_s1_idx;
    logic             r_s1_emit;
    logic             r_s1_last;
    logic             r_byp;
    t_pixel           r_byp_a, r_byp_b;

    // window column sums
    t_col_sum         r_win0, r_win1, w_cur_sum;

    // output register
    logic             r_out_valid;
    t_pixel           r_out_pix;
    logic             r_out_last;

    logic             w_in_acc, w_s1_adv, w_same_addr;
    t_pixel           w_in_pix, w_a_q, w_b_q, w_a_data, w_b_data;
    t_pixel           w_blur;

    assign w_in_pix = '{red: i_red_in, green: i_green_in, blue: i_blue_in};

    assign w_s1_adv = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall  = r_s1_valid && !w_s1_adv;
    assign w_in_acc = i_valid && !o_stall;

    // counters after a frame start takes effect, and the wrap step
    always_comb begin
        w_col_cur = i_frame_start ? '0 : r_col;
        w_row_cur = i_frame_start ? '0 : r_row;
        n_col = w_col_cur + COL_W'(1);
        n_row = w_row_cur;
        if ((DIM_W'(w_col_cur) + DIM_W'(1)) >= r_w_eff) begin
            n_col = '0;
            if ((DIM_W'(w_row_cur) + DIM_W'(1)) >= r_h_eff) n_row = '0;
            else n_row = w_row_cur + ROW_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_eff <= WIDTH_RESET;
            r_h_eff <= ROWS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LINE_WIDTH: r_w_eff <= clamp_dim(i_cfg_data, DIM_W'(MAX_WIDTH));
                CFG_FRAME_ROWS: r_h_eff <= clamp_dim(i_cfg_data, DIM_W'(MAX_ROWS));
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // line buffers: a holds the previous row, b the one before
    bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_a (
        .i_clk   (i_clk),
        .i_we    (w_s1_adv),
        .i_waddr (r_s1_idx),
        .i_wdata (r_s1_pix),
        .i_re    (w_in_acc),
        .i_raddr (w_col_cur),
        .o_rdata (w_a_q)
    );

    bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_b (
        .i_clk   (i_clk),
        .i_we    (w_s1_adv),
        .i_waddr (r_s1_idx),
        .i_wdata (w_a_data),
        .i_re    (w_in_acc),
        .i_raddr (w_col_cur),
        .o_rdata (w_b_q)
    );

    // back-to-back hit on the column being written (repeated frame starts)
    assign w_same_addr = r_s1_valid && (r_s1_idx == w_col_cur);
    assign w_a_data    = r_byp ? r_byp_a : w_a_q;
    assign w_b_data    = r_byp ? r_byp_b : w_b_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_byp      <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_valid <= 1'b1;
            r_byp      <= w_same_addr;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
            r_byp      <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_pix  <= w_in_pix;
            r_s1_idx  <= w_col_cur;
            r_s1_emit <= (w_row_cur >= ROW_W'(2)) && (w_col_cur >= COL_W'(2));
            r_s1_last <= (DIM_W'(w_row_cur) == r_h_eff - DIM_W'(1)) &&
                         (DIM_W'(w_col_cur) == r_w_eff - DIM_W'(1));
            r_byp_a   <= r_s1_pix;
            r_byp_b   <= w_a_data;
        end
    end

    always_comb begin
        w_cur_sum.red   = add3(w_b_data.red,   w_a_data.red,   r_s1_pix.red);
        w_cur_sum.green = add3(w_b_data.green, w_a_data.green, r_s1_pix.green);
        w_cur_sum.blue  = add3(w_b_data.blue,  w_a_data.blue,  r_s1_pix.blue);
        w_blur.red   = div9(TSUM_W'(r_win0.red) + TSUM_W'(r_win1.red) +
                            TSUM_W'(w_cur_sum.red));
        w_blur.green = div9(TSUM_W'(r_win0.green) + TSUM_W'(r_win1.green) +
                            TSUM_W'(w_cur_sum.green));
        w_blur.blue  = div9(TSUM_W'(r_win0.blue) + TSUM_W'(r_win1.blue) +
                            TSUM_W'(w_cur_sum.blue));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win0 <= '0;
            r_win1 <= '0;
        end else if (w_s1_adv) begin
            r_win0 <= r_win1;
            r_win1 <= w_cur_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= r_s1_emit;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_pix  <= w_blur;
            r_out_last <= r_s1_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_red_out    = r_out_pix.red;
    assign o_green_out  = r_out_pix.green;
    assign o_blue_out   = r_out_pix.blue;
    assign o_frame_last = r_out_last;

    `ASSERT_SAME(a_stall_needs_s1, o_stall, r_s1_valid, "stall with empty stage 1")
    `ASSERT_SAME(a_bypass_needs_s1, r_byp, r_s1_valid, "bypass flag without stage 1 word")
    `ASSERT_SAME(a_out_from_s1, $rose(o_valid), $past(r_s1_valid), "output without stage 1")
    `ASSERT_NEXT(a_frame_start_col, w_in_acc && i_frame_start, r_col == COL_W'(1),
                 "frame start did not restart column")

endmodule

### rtl/core/bb3_ram.sv
// Generic simple dual-port RAM, registered read, read returns old data
module bb3_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### verif/tb_box_blur_3x3_rgb_unit.sv
// Testbench for the 3x3 RGB box blur: directed and random frames checked against a behavioral blur model
`timescale 1ns / 1ps

module tb_box_blur_3x3_rgb_unit;
    import bb3_pkg::*;

    typedef struct packed {
        t_pixel px;
        logic   fs;
    } t_pixel_word;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_blur_word;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    logic [7:0]       i_red_in = 8'd0;
    logic [7:0]       i_green_in = 8'd0;
    logic [7:0]       i_blue_in = 8'd0;
    logic             i_frame_start = 1'b0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic [7:0]       o_red_out;
    logic [7:0]       o_green_out;
    logic [7:0]       o_blue_out;
    logic             o_frame_last;
    logic             i_cfg_we = 1'b0;
    t_cfg_index       i_cfg_index = CFG_LINE_WIDTH;
    logic [DIM_W-1:0] i_cfg_data = '0;

    box_blur_3x3_rgb_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .i_frame_start(i_frame_start),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out),
        .o_frame_last (o_frame_last),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_pixel_word pix_queue[$];
    t_blur_word  blur_expected[$];
    logic        pix_taken = 1'b0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          errors = 0;
    int          frame_pos = 0;

    // blur model state
    logic [DIM_W-1:0] cfg_width = WIDTH_RESET;
    logic [DIM_W-1:0] cfg_rows = ROWS_RESET;
    t_pixel           row_one_up[MAX_WIDTH];
    t_pixel           row_two_up[MAX_WIDTH];
    t_pixel           win_prev[3] = '{default: '0};
    t_pixel           win_last[3] = '{default: '0};
    int               col_cnt = 0;
    int               row_cnt = 0;

    function automatic int effective_dim(input logic [DIM_W-1:0] v);
        if (v < 3) return 3;
        if (v > 2048) return 2048;
        return int'(v);
    endfunction

    task automatic blur_step(input t_pixel px, input logic fs);
        int         w;
        int         h;
        int         idx;
        int         sr;
        int         sg;
        int         sb;
        t_pixel     col_now[3];
        t_blur_word res;
        w = effective_dim(cfg_width);
        h = effective_dim(cfg_rows);
        if (fs) begin
            col_cnt = 0;
            row_cnt = 0;
        end
        idx = col_cnt;
        col_now[0] = row_two_up[idx];
        col_now[1] = row_one_up[idx];
        col_now[2] = px;
        if (row_cnt >= 2 && col_cnt >= 2) begin
            sr = 0;
            sg = 0;
            sb = 0;
            for (int i = 0; i < 3; i++) begin
                sr += win_prev[i].red + win_last[i].red + col_now[i].red;
                sg += win_prev[i].green + win_last[i].green + col_now[i].green;
                sb += win_prev[i].blue + win_last[i].blue + col_now[i].blue;
            end
            res.red = 8'(sr / 9);
            res.green = 8'(sg / 9);
            res.blue = 8'(sb / 9);
            res.last = (row_cnt == h - 1) && (col_cnt == w - 1);
            blur_expected.push_back(res);
        end
        row_two_up[idx] = row_one_up[idx];
        row_one_up[idx] = px;
        win_prev = win_last;
        win_last = col_now;
        if (col_cnt + 1 >= w) begin
            col_cnt = 0;
            row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
        end else begin
            col_cnt++;
        end
    endtask

    // pixel driver: new word only when the last one was taken or none is up; also randomizes i_stall
    always @(negedge i_clk) begin : drive_pixels
        t_pixel_word nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < rx_idle_pct);
            if (!i_valid || pix_taken) begin
                if (pix_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    nxt = pix_queue.pop_front();
                    i_valid <= 1'b1;
                    i_red_in <= nxt.px.red;
                    i_green_in <= nxt.px.green;
                    i_blue_in <= nxt.px.blue;
                    i_frame_start <= nxt.fs;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watch_ports
        t_blur_word want;
        pix_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LINE_WIDTH: cfg_width = i_cfg_data;
                    CFG_FRAME_ROWS: cfg_rows = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !o_stall)
                blur_step(t_pixel'{i_red_in, i_green_in, i_blue_in}, i_frame_start);
            if (o_valid && !i_stall) begin
                if (blur_expected.size() == 0) begin
                    $error("unexpected blur word: red %0d green %0d blue %0d last %0d",
                           o_red_out, o_green_out, o_blue_out, o_frame_last);
                    errors++;
                end else begin
                    want = blur_expected.pop_front();
                    if (o_red_out !== want.red) begin
                        $error("red_out: expected %0d, got %0d", want.red, o_red_out);
                        errors++;
                    end
                    if (o_green_out !== want.green) begin
                        $error("green_out: expected %0d, got %0d", want.green, o_green_out);
                        errors++;
                    end
                    if (o_blue_out !== want.blue) begin
                        $error("blue_out: expected %0d, got %0d", want.blue, o_blue_out);
                        errors++;
                    end
                    if (o_frame_last !== want.last) begin
                        $error("frame_last: expected %0d, got %0d", want.last, o_frame_last);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic push_pixel(input int r, input int g, input int b, input logic fs);
        t_pixel_word pw;
        pw.px = t_pixel'{8'(r), 8'(g), 8'(b)};
        pw.fs = fs;
        pix_queue.push_back(pw);
    endtask

    function automatic int rand_chan();
        if ($urandom_range(99) < 20) return $urandom_range(1) ? 255 : 0;
        return $urandom_range(255);
    endfunction

    // frames of random content; a frame_start opens most frames, a few land mid-frame
    task automatic push_random(input int count, input int w, input int h, input bit restart);
        logic fs;
        for (int n = 0; n < count; n++) begin
            if (restart && n == 0) fs = 1'b1;
            else if (frame_pos == 0) fs = ($urandom_range(99) < 85);
            else fs = ($urandom_range(99) < 2);
            if (fs) frame_pos = 0;
            push_pixel(rand_chan(), rand_chan(), rand_chan(), fs);
            frame_pos = (frame_pos + 1) % (w * h);
        end
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pix_queue.size() != 0 || i_valid || blur_expected.size() != 0);
    endtask

    // border words can still sit in the pipe once the last result is out
    task automatic set_dims(input int width, input int rows);
        wait_drained();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_LINE_WIDTH;
        i_cfg_data <= DIM_W'(width);
        @(negedge i_clk);
        i_cfg_index <= CFG_FRAME_ROWS;
        i_cfg_data <= DIM_W'(rows);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        int width;
        int rows;
        int count;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        tx_idle_pct = 14;
        rx_idle_pct = 55;

        // both dims below the minimum: 3x3 frames, one word each
        set_dims(0, 1);
        for (int k = 0; k < 9; k++) push_pixel(255, 0, 28 * k + 31, k == 0);
        // next frame follows on wrap alone
        for (int k = 0; k < 9; k++) push_pixel(0, 255, (k % 2) ? 255 : 0, 1'b0);
        push_pixel(77, 77, 77, 1'b0);
        push_pixel(200, 3, 9, 1'b0);
        // frame_start in mid-frame; sums that truncate
        for (int k = 0; k < 9; k++) push_pixel(k, (k == 0) ? 8 : 0, 17, k == 0);

        for (int p = 0; p < 12; p++) begin
            if (p == 4) begin
                tx_idle_pct = 55;
                rx_idle_pct = 14;
            end else if (p == 8) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            count = 180;
            case (p)
                0: begin width = 3; rows = 3; end
                1: begin width = 4095; rows = 3; count = 60; end
                2: begin width = 5; rows = 4095; end
                6: begin width = 2; rows = 2; end
                9: begin width = 2048; rows = 3; count = 60; end
                default: begin
                    width = $urandom_range(24, 3);
                    rows = $urandom_range(10, 3);
                end
            endcase
            set_dims(width, rows);
            frame_pos = 0;
            push_random(count / 2, effective_dim(DIM_W'(width)),
                        effective_dim(DIM_W'(rows)), 1'b1);
            wait_drained();
            push_random(count - count / 2, effective_dim(DIM_W'(width)),
                        effective_dim(DIM_W'(rows)), 1'b0);
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
